/* design/bcw_pkg.sv */
// Shared constants and helpers for the barycentric weight pipeline.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package bcw_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int WEIGHT_BITS    = 32;
  localparam int QUOT_BITS      = 32;
  localparam int NUM_MAX_BITS   = 128;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int min2(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

/* design/bcw_dot.sv */
// Edge vectors and the five dot products, three register stages.
// Depends on bcw_pkg.
`default_nettype none
module bcw_dot #(
  parameter int CB = bcw_pkg::COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic signed [CB-1:0] p_x, p_y, p_z,
  input  wire logic signed [CB-1:0] a_x, a_y, a_z,
  input  wire logic signed [CB-1:0] b_x, b_y, b_z,
  input  wire logic signed [CB-1:0] c_x, c_y, c_z,
  output logic signed [2*CB+3:0]    d00, d01, d11, d20, d21
);
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int DOTW = 2 * CB + 4;

  logic signed [CB-1:0] p_c[3], a_c[3], b_c[3], c_c[3];
  logic signed [DW-1:0] ab_r[3], ac_r[3], ap_r[3];
  logic signed [PW-1:0] p00_r[3], p01_r[3], p11_r[3], p20_r[3], p21_r[3];
  logic signed [DOTW-1:0] d00_r, d01_r, d11_r, d20_r, d21_r;

  always_comb begin
    p_c[0] = p_x; p_c[1] = p_y; p_c[2] = p_z;
    a_c[0] = a_x; a_c[1] = a_y; a_c[2] = a_z;
    b_c[0] = b_x; b_c[1] = b_y; b_c[2] = b_z;
    c_c[0] = c_x; c_c[1] = c_y; c_c[2] = c_z;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ab_r[i]  <= DW'(b_c[i]) - DW'(a_c[i]);
      ac_r[i]  <= DW'(c_c[i]) - DW'(a_c[i]);
      ap_r[i]  <= DW'(p_c[i]) - DW'(a_c[i]);
      p00_r[i] <= PW'(ab_r[i]) * PW'(ab_r[i]);
      p01_r[i] <= PW'(ab_r[i]) * PW'(ac_r[i]);
      p11_r[i] <= PW'(ac_r[i]) * PW'(ac_r[i]);
      p20_r[i] <= PW'(ap_r[i]) * PW'(ab_r[i]);
      p21_r[i] <= PW'(ap_r[i]) * PW'(ac_r[i]);
    end
    d00_r <= DOTW'(p00_r[0]) + DOTW'(p00_r[1]) + DOTW'(p00_r[2]);
    d01_r <= DOTW'(p01_r[0]) + DOTW'(p01_r[1]) + DOTW'(p01_r[2]);
    d11_r <= DOTW'(p11_r[0]) + DOTW'(p11_r[1]) + DOTW'(p11_r[2]);
    d20_r <= DOTW'(p20_r[0]) + DOTW'(p20_r[1]) + DOTW'(p20_r[2]);
    d21_r <= DOTW'(p21_r[0]) + DOTW'(p21_r[1]) + DOTW'(p21_r[2]);
  end

  assign d00 = d00_r;
  assign d01 = d01_r;
  assign d11 = d11_r;
  assign d20 = d20_r;
  assign d21 = d21_r;
endmodule
`default_nettype wire

/* design/bcw_gram.sv */
// Gram determinant and the two weight numerators, three register stages.
// Depends on bcw_pkg; outputs numerator magnitudes and signs for the dividers.
`default_nettype none
module bcw_gram #(
  parameter int DOTW = 2 * bcw_pkg::COORD_BITS_DEF + 4,
  parameter int FB   = bcw_pkg::FRAC_BITS_DEF,
  parameter int DENW = 2 * DOTW + 1,
  parameter int NW   = bcw_pkg::min2(DENW + FB, bcw_pkg::NUM_MAX_BITS)
) (
  input  wire logic                   clk,
  input  wire logic signed [DOTW-1:0] d00, d01, d11, d20, d21,
  output logic [DENW-1:0]             den,
  output logic [NW-1:0]               mag_v, mag_w,
  output logic                        neg_v, neg_w,
  output logic                        degen
);
  localparam int PRW = 2 * DOTW;
  localparam int SNW = DENW + FB;

  logic signed [PRW-1:0]  m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [DENW-1:0] den_r, nv_r, nw_r;
  logic                   dg_r;
  logic [DENW-1:0]        den_o_r;
  logic [NW-1:0]          mag_v_r, mag_w_r;
  logic                   neg_v_r, neg_w_r, dg_o_r;
  logic [SNW-1:0]         sv, sw;
  logic signed [NW-1:0]   tv, tw;

  always_comb begin
    sv = {nv_r, {FB{1'b0}}};
    sw = {nw_r, {FB{1'b0}}};
    tv = $signed(sv[NW-1:0]);
    tw = $signed(sw[NW-1:0]);
  end

  always_ff @(posedge clk) begin
    m0_r <= PRW'(d00) * PRW'(d11);
    m1_r <= PRW'(d01) * PRW'(d01);
    m2_r <= PRW'(d11) * PRW'(d20);
    m3_r <= PRW'(d01) * PRW'(d21);
    m4_r <= PRW'(d00) * PRW'(d21);
    m5_r <= PRW'(d01) * PRW'(d20);

    den_r <= DENW'(m0_r) - DENW'(m1_r);
    nv_r  <= DENW'(m2_r) - DENW'(m3_r);
    nw_r  <= DENW'(m4_r) - DENW'(m5_r);
    dg_r  <= (m0_r == m1_r);

    den_o_r <= den_r;
    dg_o_r  <= dg_r;
    neg_v_r <= tv[NW-1];
    neg_w_r <= tw[NW-1];
    mag_v_r <= tv[NW-1] ? NW'(-tv) : NW'(tv);
    mag_w_r <= tw[NW-1] ? NW'(-tw) : NW'(tw);
  end

  assign den   = den_o_r;
  assign mag_v = mag_v_r;
  assign mag_w = mag_w_r;
  assign neg_v = neg_v_r;
  assign neg_w = neg_w_r;
  assign degen = dg_o_r;
endmodule
`default_nettype wire

/* design/bcw_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on bcw_pkg; the denominator is nonnegative, the numerator sign-magnitude.
`default_nettype none
module bcw_div #(
  parameter int DENW = 4 * bcw_pkg::COORD_BITS_DEF + 9,
  parameter int NW   = bcw_pkg::min2(DENW + bcw_pkg::FRAC_BITS_DEF, bcw_pkg::NUM_MAX_BITS)
) (
  input  wire logic                                  clk,
  input  wire logic [DENW-1:0]                       den,
  input  wire logic [NW-1:0]                         mag,
  input  wire logic                                  neg,
  output logic signed [bcw_pkg::WEIGHT_BITS-1:0]     quo
);
  localparam int QB = bcw_pkg::QUOT_BITS;
  localparam int WB = bcw_pkg::WEIGHT_BITS;
  localparam int RW = DENW + QB;
  localparam int CW = bcw_pkg::max2(NW, RW);

  // Entry 0 is the overflow-check stage; entry k+1 follows quotient step k.
  logic [RW-1:0]   rem_r[QB+1];
  logic [DENW-1:0] den_r[QB+1];
  logic [QB-1:0]   q_r[QB+1];
  logic            neg_r[QB+1];
  logic            ovf_r[QB+1];
  logic signed [WB-1:0] quo_r;

  always_ff @(posedge clk) begin
    // The quotient fits in QB bits unless mag >= den * 2^QB.
    ovf_r[0] <= CW'(mag) >= (CW'(den) << QB);
    rem_r[0] <= RW'(mag);
    den_r[0] <= den;
    neg_r[0] <= neg;
    q_r[0]   <= '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          take;
    always_comb begin
      trial = RW'(den_r[k]) << (QB - 1 - k);
      take  = rem_r[k] >= trial;
    end
    always_ff @(posedge clk) begin
      rem_r[k+1] <= take ? rem_r[k] - trial : rem_r[k];
      q_r[k+1]   <= {q_r[k][QB-2:0], take};
      den_r[k+1] <= den_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!neg_r[QB]) begin
      if (ovf_r[QB] || q_r[QB][QB-1]) begin
        quo_r <= {1'b0, {(WB-1){1'b1}}};
      end else begin
        quo_r <= $signed(WB'(q_r[QB]));
      end
    end else begin
      if (ovf_r[QB] || (q_r[QB][QB-1] && (q_r[QB][QB-2:0] != '0))) begin
        quo_r <= {1'b1, {(WB-1){1'b0}}};
      end else begin
        quo_r <= $signed(WB'(-q_r[QB]));
      end
    end
  end

  assign quo = quo_r;
endmodule
`default_nettype wire

/* design/barycentric_weights_3d_top.sv */
// Top level of the barycentric weight pipeline for 3D triangles.
// Depends on bcw_pkg, bcw_dot, bcw_gram and bcw_div.
//
// Usage: drive the query point P and corners A, B, C on the in_ ports and
// pulse start. A transaction is accepted at each rising edge where start is
// high and busy is low. busy is low whenever reset is released, so a new
// transaction may be issued on every clock cycle.
//
// Each transaction yields exactly one result transaction: out_strobe is high
// for one cycle with the weights U, V, W (signed fixed point, FRAC_BITS
// fraction bits, saturated to 32 bits) and the degenerate flag. Results come
// out in the order the inputs went in.
//
// From acceptance to out_strobe, three register stages form the edge
// vectors and dot products, three form the Gram determinant and the
// numerators, 34 run the two dividers (an overflow check, one quotient bit
// per stage for 32 bits, and saturation), and one forms U. Throughput is one
// transaction per cycle outside reset; most stages are the 32 quotient steps.
// The receiver cannot stall, so results never wait. A synchronous reset
// (rst_n low) drops every transaction in flight and holds busy high.
`default_nettype none
module barycentric_weights_3d_top #(
  parameter int COORD_BITS = bcw_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bcw_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_p_x, in_p_y, in_p_z,
  input  wire logic signed [COORD_BITS-1:0] in_a_x, in_a_y, in_a_z,
  input  wire logic signed [COORD_BITS-1:0] in_b_x, in_b_y, in_b_z,
  input  wire logic signed [COORD_BITS-1:0] in_c_x, in_c_y, in_c_z,
  output logic                              out_strobe,
  output logic signed [bcw_pkg::WEIGHT_BITS-1:0] out_weight_u,
  output logic signed [bcw_pkg::WEIGHT_BITS-1:0] out_weight_v,
  output logic signed [bcw_pkg::WEIGHT_BITS-1:0] out_weight_w,
  output logic                              out_degenerate
);
  localparam int WB      = bcw_pkg::WEIGHT_BITS;
  localparam int DOTW    = 2 * COORD_BITS + 4;
  localparam int DENW    = 2 * DOTW + 1;
  localparam int NW      = bcw_pkg::min2(DENW + FRAC_BITS, bcw_pkg::NUM_MAX_BITS);
  localparam int DIV_LAT = bcw_pkg::QUOT_BITS + 2;
  localparam int LAT     = 3 + 3 + DIV_LAT + 1;
  localparam int UW      = WB + 3;

  logic signed [DOTW-1:0] d00, d01, d11, d20, d21;
  logic [DENW-1:0]        den;
  logic [NW-1:0]          mag_v, mag_w;
  logic                   neg_v, neg_w, degen;
  logic signed [WB-1:0]   quo_v, quo_w;

  logic [LAT-1:0]     vld_r;
  logic [DIV_LAT-1:0] dg_r;
  logic signed [WB-1:0] u_r, v_r, w_r;
  logic                 dg_o_r;
  logic signed [UW-1:0] u_sum;
  logic signed [WB-1:0] u_sat;

  // Transactions are refused only while reset is held.
  assign busy = ~rst_n;

  bcw_dot #(.CB(COORD_BITS)) u_dot (
    .clk (clk),
    .p_x (in_p_x), .p_y (in_p_y), .p_z (in_p_z),
    .a_x (in_a_x), .a_y (in_a_y), .a_z (in_a_z),
    .b_x (in_b_x), .b_y (in_b_y), .b_z (in_b_z),
    .c_x (in_c_x), .c_y (in_c_y), .c_z (in_c_z),
    .d00 (d00), .d01 (d01), .d11 (d11), .d20 (d20), .d21 (d21)
  );

  bcw_gram #(.DOTW(DOTW), .FB(FRAC_BITS), .DENW(DENW), .NW(NW)) u_gram (
    .clk   (clk),
    .d00   (d00), .d01 (d01), .d11 (d11), .d20 (d20), .d21 (d21),
    .den   (den),
    .mag_v (mag_v), .mag_w (mag_w),
    .neg_v (neg_v), .neg_w (neg_w),
    .degen (degen)
  );

  bcw_div #(.DENW(DENW), .NW(NW)) u_div_v (
    .clk (clk), .den (den), .mag (mag_v), .neg (neg_v), .quo (quo_v)
  );

  bcw_div #(.DENW(DENW), .NW(NW)) u_div_w (
    .clk (clk), .den (den), .mag (mag_w), .neg (neg_w), .quo (quo_w)
  );

  // U is formed from the already saturated V and W, then saturated again.
  always_comb begin
    u_sum = (UW'(1) << FRAC_BITS) - UW'(quo_v) - UW'(quo_w);
    if (u_sum > UW'($signed({1'b0, {(WB-1){1'b1}}}))) begin
      u_sat = {1'b0, {(WB-1){1'b1}}};
    end else if (u_sum < UW'($signed({1'b1, {(WB-1){1'b0}}}))) begin
      u_sat = {1'b1, {(WB-1){1'b0}}};
    end else begin
      u_sat = u_sum[WB-1:0];
    end
  end

  // The valid bit travels alongside the data through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // The degenerate flag waits out the divider latency; a degenerate
  // triangle forces all three weights to zero.
  always_ff @(posedge clk) begin
    dg_r   <= {dg_r[DIV_LAT-2:0], degen};
    dg_o_r <= dg_r[DIV_LAT-1];
    u_r    <= dg_r[DIV_LAT-1] ? '0 : u_sat;
    v_r    <= dg_r[DIV_LAT-1] ? '0 : quo_v;
    w_r    <= dg_r[DIV_LAT-1] ? '0 : quo_w;
  end

  assign out_strobe     = vld_r[LAT-1];
  assign out_weight_u   = u_r;
  assign out_weight_v   = v_r;
  assign out_weight_w   = w_r;
  assign out_degenerate = dg_o_r;
endmodule
`default_nettype wire
